>>> rtl/core/escc_pkg.sv
// Package: shared types, constants and calendar helper functions of the epoch/calendar converter.
package escc_pkg;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] SECS_YEAR_365 = 32'd31536000;
  localparam logic [31:0] SECS_YEAR_366 = 32'd31622400;
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  // ceil(2^35/675): ((s >> 7) * DAY_RECIP) >> 35 == s / 86400, exact for any 32-bit s
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam logic [16:0] TOD_HOUR      = 17'd3600;
  localparam logic [16:0] TOD_MIN       = 17'd60;
  localparam logic [15:0] DAYS_365      = 16'd365;
  localparam logic [15:0] DAYS_366      = 16'd366;
  localparam logic [3:0]  MONTH_JAN     = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  localparam logic        OP_TO_SECS    = 1'b0;
  localparam logic        OP_TO_DATE    = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] epoch_seconds;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } escc_in_t;

  typedef struct packed {
    logic [31:0] seconds_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
  } escc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic hour_step;
    logic min_step;
    logic year_step;
    logic year_end;
    logic month_step;
    logic day_add;
    logic hms_add;
    logic out_load;
  } escc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic div_last;
    logic hour_ge;
    logic min_ge;
    logic year_more;
    logic month_more;
  } escc_sts_t;

  // 4/100/400 rule. y%25 via reciprocal 1311/2^15, exact for 12-bit years.
  // leap = y%4==0 && (y%25!=0 || y%16==0)
  function automatic logic leap_year(input logic [11:0] y);
    logic [22:0] prod;
    logic [7:0]  q;
    logic [11:0] back;
    prod = 23'(y) * 23'd1311;
    q    = prod[22:15];
    back = 12'({4'd0, q}) * 12'd25;
    return (y[1:0] == 2'd0) && ((back != y) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
      MONTH_FEB:                                   d = leap ? 5'd29 : 5'd28;
      default:                                     d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/epoch_seconds_calendar_converter_top.sv
// Top level: epoch seconds <-> Gregorian calendar converter.
//
//   channel  handshake              word
//   in       in_valid / in_ready    escc_in_t  (operation, seconds or date/time)
//   out      out_valid / out_ready  escc_out_t (seconds, or date/time fields)
//
// Work per word, from acceptance to output load, runs as one-step-per-cycle loops:
//   date to seconds: one step per year from 1970 up to year_in (none before 1970),
//     then one per month before month_in (at most twelve); then day and time are added.
//   seconds to date: the day split is a reciprocal multiply then a back-multiply;
//     then loops strip hours, minutes, years since 1970 and months.
// Reset (rst_n, synchronous) clears the controller and the output valid flag only.
// A finished word sits in the output register; a new input word is taken while it
// waits, and the converter stalls at the end of that word only if out_ready is still low.
module epoch_seconds_calendar_converter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  escc_pkg::escc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output escc_pkg::escc_out_t out_data
);
  import escc_pkg::*;

  escc_cmd_t cmd;
  escc_sts_t sts;

  // sequencer: one state per phase, loops held in a state until the status drops
  escc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic: 32-bit accumulator, reciprocal day split, calendar counters
  escc_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/escc_ctrl.sv
// Controller: sequencing state machine and output word valid flag.
module escc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  escc_pkg::escc_sts_t sts,
  output escc_pkg::escc_cmd_t cmd
);
  import escc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_HOUR  = 4'd2;
  localparam logic [3:0] S_MIN   = 4'd3;
  localparam logic [3:0] S_YEAR  = 4'd4;
  localparam logic [3:0] S_MONTH = 4'd5;
  localparam logic [3:0] S_DAY   = 4'd6;
  localparam logic [3:0] S_HMS   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.op == OP_TO_SECS) begin
          state_nxt = S_YEAR;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = S_HOUR;
        end
      end
      S_HOUR: begin
        if (sts.hour_ge) cmd.hour_step = 1'b1;
        else state_nxt = S_MIN;
      end
      S_MIN: begin
        if (sts.min_ge) cmd.min_step = 1'b1;
        else state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          cmd.year_end = 1'b1;
          state_nxt    = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts.month_more) cmd.month_step = 1'b1;
        else state_nxt = (sts.op == OP_TO_DATE) ? S_FIN : S_DAY;
      end
      S_DAY: begin
        cmd.day_add = 1'b1;
        state_nxt   = S_HMS;
      end
      S_HMS: begin
        cmd.hms_add = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/escc_dp.sv
// Datapath: accumulator, day divider, year/month stripping and output word register.
module escc_dp (
  input  logic                clk,
  input  escc_pkg::escc_in_t  in_data,
  input  escc_pkg::escc_cmd_t cmd,
  output escc_pkg::escc_sts_t sts,
  output escc_pkg::escc_out_t out_data
);
  import escc_pkg::*;

  logic        op_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [31:0] acc_r, acc_nxt;     // seconds sum, or seconds to split
  logic [16:0] rem_r, rem_nxt;     // time of day / second input
  logic        cnt_r;              // split phase: quotient, then remainder
  logic [15:0] days_r, days_nxt;
  logic [11:0] y_r, y_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  escc_out_t   out_r, out_nxt;

  logic        leap;
  logic [4:0]  mlen;
  logic [15:0] ydays;
  logic [50:0] recip_prod;
  logic [31:0] tod_full;

  assign leap       = leap_year(y_r);
  assign mlen       = month_len(leap, m_r);
  assign ydays      = leap ? DAYS_366 : DAYS_365;
  // 86400 = 128 * 675: drop the 7 low bits, then multiply by the reciprocal of 675
  assign recip_prod = 51'(acc_r[31:7]) * 51'(DAY_RECIP);
  assign tod_full   = acc_r - 32'(days_r) * SECS_PER_DAY;

  always_comb begin
    sts.op       = op_r;
    sts.div_last = cnt_r;
    sts.hour_ge  = (rem_r >= TOD_HOUR);
    sts.min_ge   = (rem_r >= TOD_MIN);
    if (op_r == OP_TO_SECS) begin
      sts.year_more  = (y_r < year_r);
      sts.month_more = (m_r < month_r) && (m_r <= MONTH_DEC);
    end else begin
      sts.year_more  = (days_r >= ydays);
      sts.month_more = (m_r < MONTH_DEC) && (days_r >= 16'(mlen));
    end
  end

  always_comb begin
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    y_nxt      = y_r;
    m_nxt      = m_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    if (cmd.load) begin
      y_nxt = EPOCH_YEAR;
      m_nxt = MONTH_JAN;
      if (in_data.operation == OP_TO_DATE) begin
        acc_nxt    = in_data.epoch_seconds;
        rem_nxt    = '0;
        hour_nxt   = '0;
        minute_nxt = '0;
      end else begin
        acc_nxt    = '0;
        rem_nxt    = 17'(in_data.second_in);
        hour_nxt   = in_data.hour_in;
        minute_nxt = in_data.minute_in;
      end
    end
    // first step: whole days; second step: time of day from the back-multiply
    if (cmd.div_step) begin
      if (!cnt_r) days_nxt = recip_prod[50:35];
      else rem_nxt = tod_full[16:0];
    end
    if (cmd.hour_step) begin
      rem_nxt  = rem_r - TOD_HOUR;
      hour_nxt = hour_r + 5'd1;
    end
    if (cmd.min_step) begin
      rem_nxt    = rem_r - TOD_MIN;
      minute_nxt = minute_r + 6'd1;
    end
    if (cmd.year_step) begin
      y_nxt = y_r + 12'd1;
      if (op_r == OP_TO_SECS) acc_nxt = acc_r + (leap ? SECS_YEAR_366 : SECS_YEAR_365);
      else days_nxt = days_r - ydays;
    end
    if (cmd.year_end && (op_r == OP_TO_SECS)) y_nxt = year_r;
    if (cmd.month_step) begin
      m_nxt = m_r + 4'd1;
      if (op_r == OP_TO_SECS) acc_nxt = acc_r + 32'(mlen) * SECS_PER_DAY;
      else days_nxt = days_r - 16'(mlen);
    end
    // day zero wraps to minus one day
    if (cmd.day_add) acc_nxt = acc_r + 32'(day_r) * SECS_PER_DAY - SECS_PER_DAY;
    if (cmd.hms_add) begin
      acc_nxt = acc_r + 32'(hour_r) * SECS_PER_HOUR + 32'(minute_r) * SECS_PER_MIN
                + 32'(rem_r);
    end
  end

  always_comb begin
    out_nxt = '0;
    if (op_r == OP_TO_SECS) begin
      out_nxt.seconds_out = acc_r;
    end else begin
      out_nxt.year_out   = y_r;
      out_nxt.month_out  = m_r;
      out_nxt.day_out    = days_r[4:0] + 5'd1;
      out_nxt.hour_out   = hour_r;
      out_nxt.minute_out = minute_r;
      out_nxt.second_out = rem_r[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.operation;
      year_r  <= in_data.year_in;
      month_r <= in_data.month_in;
      day_r   <= in_data.day_in;
      cnt_r   <= 1'b0;
    end else if (cmd.div_step) begin
      cnt_r <= ~cnt_r;
    end
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    days_r   <= days_nxt;
    y_r      <= y_nxt;
    m_r      <= m_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    if (cmd.out_load) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
